[src/dnd_pkg.sv]
package dnd_pkg;

  localparam int unsigned BUFFER_BYTES     = 512;
  localparam int unsigned MAX_NAME_BYTES   = 255;
  localparam int unsigned CHARS_PER_RESULT = 8;
  localparam int unsigned MAX_RESULTS      = 32;

  // Buffer index width, and a position width that holds any 14-bit pointer
  // target plus a carry so that an increment past the buffer end is seen.
  localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
  localparam int unsigned POS_W  = 15;
  localparam int unsigned RES_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] PTR_MIN  = 8'd192;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_HOPS  = 2'd1,
    ST_RANGE = 2'd2,
    ST_LONG  = 2'd3
  } status_e;

  typedef struct packed {
    mode_e      mode;
    logic [8:0] address;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [63:0] name_chars;
    logic [3:0]  char_count;
    logic        last_chunk;
    logic [8:0]  bytes_consumed;
    status_e     status;
  } out_t;

  // Microprogram steps.
  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_FETCH    = 4'd1,
    S_LABEL    = 4'd2,
    S_TERM     = 4'd3,
    S_PTRCHK   = 4'd4,
    S_PTRRANGE = 4'd5,
    S_HOPCHK   = 4'd6,
    S_JUMP     = 4'd7,
    S_LENCHK   = 4'd8,
    S_DOT      = 4'd9,
    S_OPEN     = 4'd10,
    S_FINAL    = 4'd11
  } step_e;

  typedef enum logic [3:0] {
    C_ALWAYS    = 4'd0,
    C_START     = 4'd1,
    C_POS_OUT   = 4'd2,
    C_IN_LABEL  = 4'd3,
    C_ZERO      = 4'd4,
    C_PTR       = 4'd5,
    C_POS1_OUT  = 4'd6,
    C_HOP_LIMIT = 4'd7,
    C_TOO_LONG  = 4'd8,
    C_HAVE_LEN  = 4'd9
  } cond_e;

  typedef enum logic [3:0] {
    A_NONE      = 4'd0,
    A_INIT      = 4'd1,
    A_READ      = 4'd2,
    A_CHAR      = 4'd3,
    A_COUNT1    = 4'd4,
    A_READ_NEXT = 4'd5,
    A_JUMP      = 4'd6,
    A_DOT       = 4'd7,
    A_OPEN      = 4'd8,
    A_LAST      = 4'd9,
    A_ST_RANGE  = 4'd10,
    A_ST_HOPS   = 4'd11,
    A_ST_LONG   = 4'd12
  } act_e;

  typedef struct packed {
    cond_e cond;
    act_e  act_t;
    step_e next_t;
    act_e  act_f;
    step_e next_f;
  } uword_t;

  // Control store: the condition picks one of two action/next-step pairs.
  function automatic uword_t dnd_ucode(step_e s);
    uword_t w;
    unique case (s)
      S_IDLE:     w = '{C_START,     A_INIT,     S_FETCH,    A_NONE,      S_IDLE};
      S_FETCH:    w = '{C_POS_OUT,   A_ST_RANGE, S_FINAL,    A_READ,      S_LABEL};
      S_LABEL:    w = '{C_IN_LABEL,  A_CHAR,     S_FETCH,    A_NONE,      S_TERM};
      S_TERM:     w = '{C_ZERO,      A_COUNT1,   S_FINAL,    A_NONE,      S_PTRCHK};
      S_PTRCHK:   w = '{C_PTR,       A_NONE,     S_PTRRANGE, A_NONE,      S_LENCHK};
      S_PTRRANGE: w = '{C_POS1_OUT,  A_ST_RANGE, S_FINAL,    A_NONE,      S_HOPCHK};
      S_HOPCHK:   w = '{C_HOP_LIMIT, A_ST_HOPS,  S_FINAL,    A_READ_NEXT, S_JUMP};
      S_JUMP:     w = '{C_ALWAYS,    A_JUMP,     S_FETCH,    A_JUMP,      S_FETCH};
      S_LENCHK:   w = '{C_TOO_LONG,  A_ST_LONG,  S_FINAL,    A_NONE,      S_DOT};
      S_DOT:      w = '{C_HAVE_LEN,  A_DOT,      S_OPEN,     A_NONE,      S_OPEN};
      S_OPEN:     w = '{C_ALWAYS,    A_OPEN,     S_FETCH,    A_OPEN,      S_FETCH};
      S_FINAL:    w = '{C_ALWAYS,    A_LAST,     S_IDLE,     A_LAST,      S_IDLE};
      default:    w = '{C_ALWAYS,    A_NONE,     S_IDLE,     A_NONE,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[src/dns_name_decompressor.sv]
// Channel  | Direction | Handshake            | Beat
// ---------+-----------+----------------------+----------------------------------
// in       | input     | in_valid_i/in_stall_o | mode, address, data_byte
// out      | output    | out_valid_o/out_stall_i | chars, count, last, consumed, status
// cfg      | input     | cfg_valid_i/cfg_ready_o | max_pointer_hops (6 bits)
//
// A decode runs one control word per cycle, with one buffer read port behind it,
// while no output stall holds the sequencer.
// Reset clears control state and sets the hop limit to 16; the buffer is not cleared.
// The input is stalled for the whole decode. A chunk waits in the output register
// while the next characters are gathered; the sequencer holds only when a second
// chunk is ready and the first has not been taken.
module dns_name_decompressor (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dnd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dnd_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [5:0]    cfg_data_i
);

  localparam int unsigned PosW  = dnd_pkg::POS_W;
  localparam int unsigned AddrW = dnd_pkg::ADDR_W;
  localparam int unsigned ResW  = dnd_pkg::RES_W;

  logic [7:0] mem [dnd_pkg::BUFFER_BYTES];
  logic [7:0] byte_q;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [PosW-1:0]  in_addr;

  dnd_pkg::step_e   step_q, step_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [5:0]       hops_q, hops_d;
  logic             jumped_q, jumped_d;
  logic [7:0]       lrem_q, lrem_d;
  logic [8:0]       consumed_q, consumed_d;
  logic [8:0]       nlen_q, nlen_d;
  logic [63:0]      pack_q, pack_d;
  logic [3:0]       fill_q, fill_d;
  logic [ResW-1:0]  nres_q, nres_d;
  dnd_pkg::status_e status_q, status_d;
  logic [7:0]       hi_q, hi_d;
  logic [5:0]       max_hops_q;
  logic             out_valid_q, out_valid_d;
  dnd_pkg::out_t    out_q, out_d;

  dnd_pkg::uword_t  uw;
  logic             cond;
  dnd_pkg::act_e    act;
  dnd_pkg::step_e   nxt;
  logic             full;
  logic             chunk_ok;
  logic             emit_req;
  logic             hold;
  logic             push_en;
  logic [7:0]       push_c;
  logic [PosW-1:0]  pos_inc;
  logic [9:0]       len_sum;

  assign in_stall_o  = (step_q != dnd_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_addr = PosW'(in_data_i.address);
  assign wr_en   = in_valid_i && !in_stall_o && (in_data_i.mode == dnd_pkg::MODE_WRITE)
                   && (in_addr < PosW'(dnd_pkg::BUFFER_BYTES));

  assign pos_inc  = pos_q + PosW'(1);
  assign len_sum  = {1'b0, nlen_q} + {2'b00, byte_q} + 10'd2;
  assign full     = (fill_q >= 4'(dnd_pkg::CHARS_PER_RESULT));
  assign chunk_ok = (nres_q < ResW'(dnd_pkg::MAX_RESULTS - 1));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[in_addr[AddrW-1:0]] <= in_data_i.data_byte;
    end
    if (rd_en) begin
      byte_q <= mem[rd_addr];
    end
  end

  always_comb begin
    uw = dnd_pkg::dnd_ucode(step_q);
    unique case (uw.cond)
      dnd_pkg::C_ALWAYS:    cond = 1'b1;
      dnd_pkg::C_START:     cond = in_valid_i && (in_data_i.mode == dnd_pkg::MODE_DECODE);
      dnd_pkg::C_POS_OUT:   cond = (pos_q >= PosW'(dnd_pkg::BUFFER_BYTES));
      dnd_pkg::C_IN_LABEL:  cond = (lrem_q != 8'd0);
      dnd_pkg::C_ZERO:      cond = (byte_q == 8'd0);
      dnd_pkg::C_PTR:       cond = (byte_q >= dnd_pkg::PTR_MIN);
      dnd_pkg::C_POS1_OUT:  cond = (pos_inc >= PosW'(dnd_pkg::BUFFER_BYTES));
      dnd_pkg::C_HOP_LIMIT: cond = (hops_q >= max_hops_q);
      dnd_pkg::C_TOO_LONG:  cond = (len_sum > 10'(dnd_pkg::MAX_NAME_BYTES));
      dnd_pkg::C_HAVE_LEN:  cond = (nlen_q != 9'd0);
      default:              cond = 1'b0;
    endcase
    act = cond ? uw.act_t : uw.act_f;
    nxt = cond ? uw.next_t : uw.next_f;

    emit_req = (act == dnd_pkg::A_LAST) ||
               (((act == dnd_pkg::A_CHAR) || (act == dnd_pkg::A_DOT)) && full && chunk_ok);
    hold     = emit_req && out_valid_q && out_stall_i;

    step_d     = step_q;
    pos_d      = pos_q;
    hops_d     = hops_q;
    jumped_d   = jumped_q;
    lrem_d     = lrem_q;
    consumed_d = consumed_q;
    nlen_d     = nlen_q;
    pack_d     = pack_q;
    fill_d     = fill_q;
    nres_d     = nres_q;
    status_d   = status_q;
    hi_d       = hi_q;
    rd_en      = 1'b0;
    rd_addr    = pos_q[AddrW-1:0];
    push_en    = 1'b0;
    push_c     = byte_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (!hold) begin
      step_d = nxt;
      case (act)
        dnd_pkg::A_INIT: begin
          pos_d      = in_addr;
          hops_d     = '0;
          jumped_d   = 1'b0;
          lrem_d     = '0;
          consumed_d = '0;
          nlen_d     = '0;
          pack_d     = '0;
          fill_d     = '0;
          nres_d     = '0;
          status_d   = dnd_pkg::ST_OK;
        end
        dnd_pkg::A_READ: begin
          rd_en = 1'b1;
        end
        dnd_pkg::A_CHAR: begin
          push_en = 1'b1;
          lrem_d  = lrem_q - 8'd1;
          pos_d   = pos_inc;
          if (!jumped_q) consumed_d = consumed_q + 9'd1;
        end
        dnd_pkg::A_COUNT1: begin
          if (!jumped_q) consumed_d = consumed_q + 9'd1;
        end
        dnd_pkg::A_READ_NEXT: begin
          rd_en   = 1'b1;
          rd_addr = pos_inc[AddrW-1:0];
          hi_d    = byte_q;
        end
        dnd_pkg::A_JUMP: begin
          // Pointer target is the low 14 bits of the two pointer bytes.
          hops_d   = hops_q + 6'd1;
          if (!jumped_q) consumed_d = consumed_q + 9'd2;
          jumped_d = 1'b1;
          pos_d    = PosW'({hi_q[5:0], byte_q});
        end
        dnd_pkg::A_DOT: begin
          push_en = 1'b1;
          push_c  = dnd_pkg::DOT_CHAR;
        end
        dnd_pkg::A_OPEN: begin
          nlen_d = nlen_q + 9'(byte_q) + 9'd1;
          lrem_d = byte_q;
          pos_d  = pos_inc;
          if (!jumped_q) consumed_d = consumed_q + 9'd1;
        end
        dnd_pkg::A_LAST: begin
          out_valid_d = 1'b1;
          out_d = '{name_chars: pack_q, char_count: fill_q, last_chunk: 1'b1,
                    bytes_consumed: consumed_q, status: status_q};
        end
        dnd_pkg::A_ST_RANGE: status_d = dnd_pkg::ST_RANGE;
        dnd_pkg::A_ST_HOPS:  status_d = dnd_pkg::ST_HOPS;
        dnd_pkg::A_ST_LONG:  status_d = dnd_pkg::ST_LONG;
        default: ;
      endcase

      if (push_en) begin
        if (full) begin
          // A full chunk goes out only when the next character arrives; past the
          // result budget it is dropped.
          if (chunk_ok) begin
            out_valid_d = 1'b1;
            out_d = '{name_chars: pack_q, char_count: fill_q, last_chunk: 1'b0,
                      bytes_consumed: 9'd0, status: dnd_pkg::ST_OK};
            nres_d = nres_q + ResW'(1);
          end
          pack_d = {56'd0, push_c};
          fill_d = 4'd1;
        end else begin
          for (int i = 0; i < dnd_pkg::CHARS_PER_RESULT; i++) begin
            if (fill_q == 4'(i)) pack_d[8*i +: 8] = push_c;
          end
          fill_d = fill_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= dnd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      max_hops_q  <= 6'd16;
      pos_q       <= '0;
      hops_q      <= '0;
      jumped_q    <= 1'b0;
      lrem_q      <= '0;
      consumed_q  <= '0;
      nlen_q      <= '0;
      fill_q      <= '0;
      nres_q      <= '0;
      status_q    <= dnd_pkg::ST_OK;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) max_hops_q <= cfg_data_i;
      pos_q       <= pos_d;
      hops_q      <= hops_d;
      jumped_q    <= jumped_d;
      lrem_q      <= lrem_d;
      consumed_q  <= consumed_d;
      nlen_q      <= nlen_d;
      fill_q      <= fill_d;
      nres_q      <= nres_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pack_q <= pack_d;
    hi_q   <= hi_d;
    out_q  <= out_d;
  end

endmodule

[dv/tb_dns_name_decompressor.sv]
module tb_dns_name_decompressor;

  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned STALL_LIMIT  = 20000;

  logic           clk;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall_o;
  dnd_pkg::in_t   in_data   = '0;
  logic           out_valid_o;
  logic           out_stall = 1'b0;
  dnd_pkg::out_t  out_data_o;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready_o;
  logic [5:0]     cfg_data  = '0;

  dns_name_decompressor u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  // Shadow copy of the message buffer, with a flag per byte that was written.
  logic [7:0]    msg_mem  [dnd_pkg::BUFFER_BYTES];
  bit            msg_seen [dnd_pkg::BUFFER_BYTES];
  logic [5:0]    hop_limit = 6'd16;
  logic [63:0]   pend_chars;
  int unsigned   pend_fill;
  int unsigned   chunk_num;
  dnd_pkg::out_t chunk_q [$];
  logic [8:0]    name_starts [$];
  int unsigned   beats_sent = 0;
  int unsigned   err_count  = 0;
  int unsigned   idle_run   = 0;
  bit            no_gaps    = 1'b0;

  typedef struct {
    dnd_pkg::mode_e mode;
    logic [8:0]     addr;
    logic [7:0]     data;
    bit             typed;
    dnd_pkg::out_t  want;
  } dir_row_t;

  dir_row_t dir_rows [24] = '{
    '{dnd_pkg::MODE_WRITE,  9'd0, 8'h00, 1'b0, '0},
    '{dnd_pkg::MODE_DECODE, 9'd0, 8'hFF, 1'b1, '{64'h0, 4'd0, 1'b1, 9'd1, dnd_pkg::ST_OK}},
    '{dnd_pkg::MODE_WRITE,  9'd511, 8'h00, 1'b0, '0},
    '{dnd_pkg::MODE_DECODE, 9'd511, 8'h00, 1'b1, '{64'h0, 4'd0, 1'b1, 9'd1, dnd_pkg::ST_OK}},
    '{dnd_pkg::MODE_WRITE,  9'd511, 8'hC0, 1'b0, '0},
    '{dnd_pkg::MODE_DECODE, 9'd511, 8'hFF, 1'b1,
      '{64'h0, 4'd0, 1'b1, 9'd0, dnd_pkg::ST_RANGE}},
    '{dnd_pkg::MODE_WRITE,  9'd2, 8'hC0, 1'b0, '0},
    '{dnd_pkg::MODE_WRITE,  9'd3, 8'h02, 1'b0, '0},
    '{dnd_pkg::MODE_DECODE, 9'd2, 8'h00, 1'b1, '{64'h0, 4'd0, 1'b1, 9'd2, dnd_pkg::ST_HOPS}},
    '{dnd_pkg::MODE_WRITE,  9'd20, 8'hFF, 1'b0, '0},
    '{dnd_pkg::MODE_WRITE,  9'd21, 8'hFF, 1'b0, '0},
    '{dnd_pkg::MODE_DECODE, 9'd20, 8'hFF, 1'b1,
      '{64'h0, 4'd0, 1'b1, 9'd2, dnd_pkg::ST_RANGE}},
    '{dnd_pkg::MODE_WRITE,  9'd509, 8'd100, 1'b0, '0},
    '{dnd_pkg::MODE_WRITE,  9'd510, 8'h61, 1'b0, '0},
    '{dnd_pkg::MODE_WRITE,  9'd511, 8'h62, 1'b0, '0},
    '{dnd_pkg::MODE_DECODE, 9'd509, 8'h00, 1'b1,
      '{64'h6261, 4'd2, 1'b1, 9'd3, dnd_pkg::ST_RANGE}},
    '{dnd_pkg::MODE_WRITE,  9'd30, 8'h03, 1'b0, '0},
    '{dnd_pkg::MODE_WRITE,  9'd31, 8'h77, 1'b0, '0},
    '{dnd_pkg::MODE_WRITE,  9'd32, 8'h77, 1'b0, '0},
    '{dnd_pkg::MODE_WRITE,  9'd33, 8'h77, 1'b0, '0},
    '{dnd_pkg::MODE_WRITE,  9'd34, 8'hC0, 1'b0, '0},
    '{dnd_pkg::MODE_WRITE,  9'd35, 8'h00, 1'b0, '0},
    '{dnd_pkg::MODE_DECODE, 9'd30, 8'h00, 1'b0, '0},
    '{dnd_pkg::MODE_DECODE, 9'd34, 8'hFF, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Appends one character to the pending chunk, flushing a full chunk first.
  function automatic void put_char(input logic [7:0] c, input bit commit);
    if (pend_fill >= dnd_pkg::CHARS_PER_RESULT) begin
      if (commit && chunk_num < dnd_pkg::MAX_RESULTS - 1) begin
        chunk_q.push_back(dnd_pkg::out_t'{pend_chars, 4'(pend_fill), 1'b0, 9'd0,
                                          dnd_pkg::ST_OK});
        chunk_num++;
      end
      pend_chars = '0;
      pend_fill  = 0;
    end
    pend_chars[8*pend_fill +: 8] = c;
    pend_fill++;
  endfunction

  // Walks the name at start. Without commit it only reports the first buffer
  // byte that the walk would read before it was ever written (or -1). With
  // commit it queues the chunks that the block must produce.
  function automatic int walk_name(input logic [8:0] start, input bit commit);
    int unsigned      pos;
    int unsigned      hops;
    int unsigned      remain;
    int unsigned      wire_len;
    logic [8:0]       used;
    bit               jumped;
    logic [7:0]       b;
    logic [7:0]       nxt;
    dnd_pkg::status_e st;
    pos = start;
    hops = 0;
    remain = 0;
    wire_len = 0;
    used = '0;
    jumped = 1'b0;
    st = dnd_pkg::ST_OK;
    pend_chars = '0;
    pend_fill = 0;
    chunk_num = 0;
    while (1) begin
      if (pos >= dnd_pkg::BUFFER_BYTES) begin
        st = dnd_pkg::ST_RANGE;
        break;
      end
      if (!msg_seen[pos]) return int'(pos);
      b = msg_mem[pos];
      if (remain > 0) begin
        put_char(b, commit);
        remain--;
        pos++;
        if (!jumped) used = used + 9'd1;
        continue;
      end
      if (b == 8'h00) begin
        if (!jumped) used = used + 9'd1;
        break;
      end
      if (b >= dnd_pkg::PTR_MIN) begin
        if (pos + 1 >= dnd_pkg::BUFFER_BYTES) begin
          st = dnd_pkg::ST_RANGE;
          break;
        end
        if (hops >= hop_limit) begin
          st = dnd_pkg::ST_HOPS;
          break;
        end
        if (!msg_seen[pos + 1]) return int'(pos + 1);
        nxt = msg_mem[pos + 1];
        hops++;
        if (!jumped) used = used + 9'd2;
        jumped = 1'b1;
        pos = ((int'(b) << 8) + int'(nxt) - 49152) & 'h3FFF;
        continue;
      end
      // Length byte, characters and the closing zero must fit the name limit.
      if (wire_len + 1 + b + 1 > dnd_pkg::MAX_NAME_BYTES) begin
        st = dnd_pkg::ST_LONG;
        break;
      end
      if (wire_len > 0) put_char(dnd_pkg::DOT_CHAR, commit);
      wire_len += 1 + b;
      remain = b;
      pos++;
      if (!jumped) used = used + 9'd1;
    end
    if (commit) begin
      chunk_q.push_back(dnd_pkg::out_t'{pend_chars, 4'(pend_fill), 1'b1, used, st});
    end
    return -1;
  endfunction

  task automatic send_beat(input dnd_pkg::mode_e mode, input logic [8:0] addr,
                           input logic [7:0] data, input bit typed = 1'b0,
                           input dnd_pkg::out_t want = '0);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= dnd_pkg::in_t'{mode, addr, data};
    do @(posedge clk); while (in_stall_o);
    beats_sent++;
    if (mode == dnd_pkg::MODE_WRITE) begin
      msg_mem[addr]  = data;
      msg_seen[addr] = 1'b1;
    end else if (typed) begin
      chunk_q.push_back(want);
    end else begin
      void'(walk_name(addr, 1'b1));
    end
  endtask

  // Any byte the walk would read unwritten gets a random value first, biased
  // toward terminators and short labels so that the walk ends soon.
  task automatic issue_decode(input logic [8:0] start);
    int miss;
    logic [7:0] fill;
    miss = walk_name(start, 1'b0);
    while (miss >= 0) begin
      case ($urandom_range(0, 3))
        0:       fill = 8'h00;
        1, 2:    fill = 8'($urandom_range(1, 8));
        default: fill = 8'($urandom);
      endcase
      send_beat(dnd_pkg::MODE_WRITE, 9'(miss), fill);
      miss = walk_name(start, 1'b0);
    end
    send_beat(dnd_pkg::MODE_DECODE, start, 8'($urandom));
  endtask

  task automatic build_name(input bit self_loop, output logic [8:0] start);
    logic [7:0]  wire_bytes [$];
    int unsigned nlab;
    int unsigned len;
    int unsigned tail;
    int unsigned base;
    logic [8:0]  target;
    nlab = self_loop ? 1 : $urandom_range(1, 3);
    repeat (nlab) begin
      if (self_loop) len = $urandom_range(1, 8);
      else len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      wire_bytes.push_back(8'(len));
      repeat (len) wire_bytes.push_back(8'($urandom));
    end
    if (self_loop) tail = 2;
    else if (name_starts.size() != 0 && $urandom_range(0, 1) == 1) tail = 1;
    else tail = 0;
    base = $urandom_range(0, dnd_pkg::BUFFER_BYTES - wire_bytes.size() - (tail == 0 ? 1 : 2));
    if (tail == 0) begin
      wire_bytes.push_back(8'h00);
    end else begin
      target = (tail == 2) ? 9'(base) : name_starts[$urandom_range(0, name_starts.size() - 1)];
      wire_bytes.push_back(dnd_pkg::PTR_MIN | {7'd0, target[8]});
      wire_bytes.push_back(target[7:0]);
    end
    foreach (wire_bytes[k]) send_beat(dnd_pkg::MODE_WRITE, 9'(base + k), wire_bytes[k]);
    if (!self_loop) name_starts.push_back(9'(base));
    start = 9'(base);
  endtask

  task automatic set_hop_limit(input logic [5:0] lim);
    in_valid <= 1'b0;
    while (chunk_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    hop_limit = lim;
  endtask

  task automatic run_random(input int unsigned n_beats);
    int unsigned stop_beats;
    logic [8:0]  start;
    stop_beats = beats_sent + n_beats;
    while (beats_sent < stop_beats) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          build_name(1'b0, start);
          issue_decode(start);
        end
        3: begin
          build_name(1'b1, start);
          issue_decode(start);
        end
        4, 5, 6: begin
          if (name_starts.size() != 0)
            issue_decode(name_starts[$urandom_range(0, name_starts.size() - 1)]);
          else
            issue_decode(9'($urandom));
        end
        7:       send_beat(dnd_pkg::MODE_WRITE, 9'($urandom), 8'($urandom));
        default: issue_decode(9'($urandom));
      endcase
    end
  endtask

  initial begin : stimulus
    foreach (msg_seen[i]) msg_seen[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].mode, dir_rows[i].addr, dir_rows[i].data,
                dir_rows[i].typed, dir_rows[i].want);

    set_hop_limit(6'd63);
    run_random(20);
    set_hop_limit(6'd1);
    run_random(20);
    set_hop_limit(6'($urandom_range(2, 62)));
    no_gaps = 1'b1;
    run_random(20);
    set_hop_limit(6'd16);
    no_gaps = 1'b0;
    run_random(20);

    in_valid <= 1'b0;
    while (chunk_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("** dns_name_decompressor: PASSED **");
    end else begin
      $display("** dns_name_decompressor: FAILED **");
    end
    $finish;
  end

  // Receiver: holds stall for a random gap before each beat, unless no_gaps is set.
  initial begin : result_sink
    int unsigned gap;
    wait (rst_n);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid_o && !out_stall));
    end
  end

  always @(posedge clk) begin : check_results
    dnd_pkg::out_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (chunk_q.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data_o);
        err_count++;
      end else begin
        want = chunk_q.pop_front();
        if (out_data_o.name_chars !== want.name_chars) begin
          $error("name_chars: expected %h, got %h", want.name_chars, out_data_o.name_chars);
          err_count++;
        end
        if (out_data_o.char_count !== want.char_count) begin
          $error("char_count: expected %0d, got %0d", want.char_count, out_data_o.char_count);
          err_count++;
        end
        if (out_data_o.last_chunk !== want.last_chunk) begin
          $error("last_chunk: expected %0d, got %0d", want.last_chunk, out_data_o.last_chunk);
          err_count++;
        end
        if (out_data_o.bytes_consumed !== want.bytes_consumed) begin
          $error("bytes_consumed: expected %0d, got %0d", want.bytes_consumed,
                 out_data_o.bytes_consumed);
          err_count++;
        end
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          err_count++;
        end
      end
    end
  end

  // Ends the run if no channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      idle_run = 0;
    else
      idle_run++;
    if (idle_run >= STALL_LIMIT) begin
      $display("** dns_name_decompressor: FAILED **");
      $finish;
    end
  end

endmodule

[files.f]
src/dnd_pkg.sv
src/dns_name_decompressor.sv
dv/tb_dns_name_decompressor.sv
